// ----- sv/fixed_point_alu_top_macros.svh -----
// Assertion macros for the fixed-point ALU checker.
// Relies on signals named clock and reset in the scope of use.
`ifndef FIXED_POINT_ALU_TOP_MACROS_SVH
`define FIXED_POINT_ALU_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset
`define FPA_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define FPA_CHECK_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- sv/fpa_pkg.sv -----
// Shared types and constants of the fixed-point ALU.
// No dependencies.
package fpa_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int FRAC_BITS_DEF = 8;

   typedef enum logic [3:0] {
      FUNC_ADD      = 4'd0,
      FUNC_SUB      = 4'd1,
      FUNC_MUL      = 4'd2,
      FUNC_DIV      = 4'd3,
      FUNC_LT       = 4'd4,
      FUNC_GT       = 4'd5,
      FUNC_LE       = 4'd6,
      FUNC_GE       = 4'd7,
      FUNC_EQ       = 4'd8,
      FUNC_NE       = 4'd9,
      FUNC_MIN      = 4'd10,
      FUNC_MAX      = 4'd11,
      FUNC_INC      = 4'd12,
      FUNC_DEC      = 4'd13,
      FUNC_FROM_INT = 4'd14,
      FUNC_TO_INT   = 4'd15
   } func_type;

   typedef struct packed {
      func_type                  func;
      logic signed [DATA_W-1:0]  operand_a;
      logic signed [DATA_W-1:0]  operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result;
      logic                      flag;
      logic                      div_by_zero;
   } rsp_type;

   // Control that travels alongside each word through the divider cells
   typedef struct packed {
      logic valid;
      logic is_div;
      logic neg;
      logic dbz;
      logic flag;
   } cell_ctl_type;

endpackage

// ----- sv/fpa_front.sv -----
// Front end of the fixed-point ALU: operand register with multiplier,
// then every non-divide result and the divider set-up. Uses fpa_pkg.
module fpa_front #(
   parameter int FRAC_BITS = 8,
   parameter int DVD_W     = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  fpa_pkg::req_type                req,
   output fpa_pkg::cell_ctl_type           ctl_dn,
   output logic [fpa_pkg::DATA_W-1:0]      rem_dn,
   output logic [DVD_W-1:0]                dvd_dn,
   output logic [fpa_pkg::DATA_W-1:0]      dsr_dn,
   output logic signed [fpa_pkg::DATA_W-1:0] res_dn
);
   import fpa_pkg::*;

   localparam logic signed [PROD_W-1:0] MulBias =
      (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

   logic                       s1_valid_ff;
   func_type                   s1_func_ff;
   logic signed [DATA_W-1:0]   s1_a_ff;
   logic signed [DATA_W-1:0]   s1_b_ff;
   logic signed [PROD_W-1:0]   s1_prod_ff;

   cell_ctl_type               ctl_ff, ctl_in;
   logic signed [DATA_W-1:0]   res_ff, res_in;
   logic [DVD_W-1:0]           dvd_ff, dvd_in;
   logic [DATA_W-1:0]          dsr_ff, dsr_in;

   logic signed [PROD_W-1:0]   prod_biased;
   logic signed [DATA_W-1:0]   mul_res;
   logic [DATA_W-1:0]          abs_a;
   logic [DATA_W-1:0]          abs_b;

   // Capture the word and form the full product
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_func_ff <= req.func;
      s1_a_ff    <= req.operand_a;
      s1_b_ff    <= req.operand_b;
      s1_prod_ff <= PROD_W'(req.operand_a) * PROD_W'(req.operand_b);
   end

   // Scale the product down, truncating toward zero
   always_comb begin
      prod_biased = s1_prod_ff + (s1_prod_ff[PROD_W-1] ? MulBias : '0);
      mul_res     = prod_biased[FRAC_BITS +: DATA_W];
   end

   // Operand magnitudes for the divider
   assign abs_a = s1_a_ff[DATA_W-1] ? (~s1_a_ff + DATA_W'(1)) : s1_a_ff;
   assign abs_b = s1_b_ff[DATA_W-1] ? (~s1_b_ff + DATA_W'(1)) : s1_b_ff;

   // Decode the operation
   always_comb begin
      ctl_in        = '0;
      ctl_in.valid  = s1_valid_ff;
      ctl_in.neg    = s1_a_ff[DATA_W-1] ^ s1_b_ff[DATA_W-1];
      res_in        = '0;
      dvd_in        = {abs_a, {FRAC_BITS{1'b0}}};
      dsr_in        = abs_b;
      case (s1_func_ff)
         FUNC_ADD:      res_in = s1_a_ff + s1_b_ff;
         FUNC_SUB:      res_in = s1_a_ff - s1_b_ff;
         FUNC_MUL:      res_in = mul_res;
         FUNC_DIV: begin
            ctl_in.is_div = 1'b1;
            ctl_in.dbz    = (s1_b_ff == '0);
         end
         FUNC_LT:       ctl_in.flag = (s1_a_ff <  s1_b_ff);
         FUNC_GT:       ctl_in.flag = (s1_a_ff >  s1_b_ff);
         FUNC_LE:       ctl_in.flag = (s1_a_ff <= s1_b_ff);
         FUNC_GE:       ctl_in.flag = (s1_a_ff >= s1_b_ff);
         FUNC_EQ:       ctl_in.flag = (s1_a_ff == s1_b_ff);
         FUNC_NE:       ctl_in.flag = (s1_a_ff != s1_b_ff);
         FUNC_MIN:      res_in = (s1_a_ff < s1_b_ff) ? s1_a_ff : s1_b_ff;
         FUNC_MAX:      res_in = (s1_a_ff > s1_b_ff) ? s1_a_ff : s1_b_ff;
         FUNC_INC:      res_in = s1_a_ff + DATA_W'(1);
         FUNC_DEC:      res_in = s1_a_ff - DATA_W'(1);
         FUNC_FROM_INT: res_in = s1_a_ff << FRAC_BITS;
         FUNC_TO_INT:   res_in = s1_a_ff >>> FRAC_BITS;
         default:       res_in = '0;
      endcase
   end

   // Hold the prepared word for the first cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      res_ff <= res_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign ctl_dn = ctl_ff;
   assign rem_dn = '0;
   assign dvd_dn = dvd_ff;
   assign dsr_dn = dsr_ff;
   assign res_dn = res_ff;

endmodule

// ----- sv/fpa_cell.sv -----
// One restoring-division cell: one quotient bit per word, then hand on.
// Uses fpa_pkg.
module fpa_cell #(
   parameter int DVD_W = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fpa_pkg::cell_ctl_type             ctl_up,
   input  logic [fpa_pkg::DATA_W-1:0]        rem_up,
   input  logic [DVD_W-1:0]                  dvd_up,
   input  logic [fpa_pkg::DATA_W-1:0]        dsr_up,
   input  logic signed [fpa_pkg::DATA_W-1:0] res_up,
   output fpa_pkg::cell_ctl_type             ctl_dn,
   output logic [fpa_pkg::DATA_W-1:0]        rem_dn,
   output logic [DVD_W-1:0]                  dvd_dn,
   output logic [fpa_pkg::DATA_W-1:0]        dsr_dn,
   output logic signed [fpa_pkg::DATA_W-1:0] res_dn
);
   import fpa_pkg::*;

   cell_ctl_type              ctl_ff;
   logic [DATA_W-1:0]         rem_ff, rem_in;
   logic [DVD_W-1:0]          dvd_ff, dvd_in;
   logic [DATA_W-1:0]         dsr_ff;
   logic signed [DATA_W-1:0]  res_ff;

   logic [DATA_W:0]           trial;
   logic [DATA_W:0]           diff;
   logic                      take;

   // Bring down the next dividend bit and try the subtract
   always_comb begin
      trial  = {rem_up, dvd_up[DVD_W-1]};
      diff   = trial - {1'b0, dsr_up};
      take   = ~diff[DATA_W];
      rem_in = take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dvd_in = {dvd_up[DVD_W-2:0], take};
   end

   // Advance the word to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_up;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_up;
      res_ff <= res_up;
   end

   assign ctl_dn = ctl_ff;
   assign rem_dn = rem_ff;
   assign dvd_dn = dvd_ff;
   assign dsr_dn = dsr_ff;
   assign res_dn = res_ff;

endmodule

// ----- sv/fpa_back.sv -----
// Back end of the fixed-point ALU: quotient sign fix-up, result select
// and the registered result port. Uses fpa_pkg.
module fpa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  fpa_pkg::cell_ctl_type             ctl_up,
   input  logic [fpa_pkg::DATA_W-1:0]        quo_up,
   input  logic signed [fpa_pkg::DATA_W-1:0] res_up,
   output logic                              strobe,
   output fpa_pkg::rsp_type                  rsp
);
   import fpa_pkg::*;

   logic    strobe_ff;
   rsp_type rsp_ff, rsp_in;

   // Pick the final result; a divide by zero gives zero
   always_comb begin
      rsp_in.flag        = ctl_up.flag;
      rsp_in.div_by_zero = ctl_up.dbz;
      if (ctl_up.is_div) begin
         if (ctl_up.dbz) begin
            rsp_in.result = '0;
         end else if (ctl_up.neg) begin
            rsp_in.result = ~quo_up + DATA_W'(1);
         end else begin
            rsp_in.result = quo_up;
         end
      end else begin
         rsp_in.result = res_up;
      end
   end

   // Register the result word and its strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_up.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign strobe = strobe_ff;
   assign rsp    = rsp_ff;

endmodule

// ----- sv/fixed_point_alu_top.sv -----
// Fixed-point ALU top level: front end, a chain of divider cells, back end.
// Every operation passes two front stages, one cell per dividend bit
// (32 + FRAC_BITS) and one output stage.
// Throughput is one word per cycle; busy stays low, results cannot stall.
// Synchronous reset clears the valid and control flags of every stage; data registers are not reset.
module fixed_point_alu_top #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fpa_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output fpa_pkg::rsp_type  rsp_data
);
   import fpa_pkg::*;

   localparam int DVD_W = DATA_W + FRAC_BITS;

   cell_ctl_type              ctl_node [DVD_W+1];
   logic [DATA_W-1:0]         rem_node [DVD_W+1];
   logic [DVD_W-1:0]          dvd_node [DVD_W+1];
   logic [DATA_W-1:0]         dsr_node [DVD_W+1];
   logic signed [DATA_W-1:0]  res_node [DVD_W+1];

   // Every word is taken as it arrives
   assign busy = 1'b0;

   fpa_front #(
      .FRAC_BITS (FRAC_BITS),
      .DVD_W     (DVD_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (start & ~busy),
      .req    (req_data),
      .ctl_dn (ctl_node[0]),
      .rem_dn (rem_node[0]),
      .dvd_dn (dvd_node[0]),
      .dsr_dn (dsr_node[0]),
      .res_dn (res_node[0])
   );

   // One cell per quotient bit
   for (genvar i = 0; i < DVD_W; i++) begin : g_cell
      fpa_cell #(
         .DVD_W (DVD_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_up (ctl_node[i]),
         .rem_up (rem_node[i]),
         .dvd_up (dvd_node[i]),
         .dsr_up (dsr_node[i]),
         .res_up (res_node[i]),
         .ctl_dn (ctl_node[i+1]),
         .rem_dn (rem_node[i+1]),
         .dvd_dn (dvd_node[i+1]),
         .dsr_dn (dsr_node[i+1]),
         .res_dn (res_node[i+1])
      );
   end

   fpa_back u_back (
      .clock  (clock),
      .reset  (reset),
      .ctl_up (ctl_node[DVD_W]),
      .quo_up (dvd_node[DVD_W][DATA_W-1:0]),
      .res_up (res_node[DVD_W]),
      .strobe (rsp_strobe),
      .rsp    (rsp_data)
   );

endmodule

// ----- sv/fpa_checker.sv -----
// Port-level checks of the fixed-point ALU, bound to the top level.
// Uses fpa_pkg and fixed_point_alu_top_macros.svh.
`include "fixed_point_alu_top_macros.svh"

module fpa_checker #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  fpa_pkg::req_type  req_data,
   input  logic              rsp_strobe,
   input  fpa_pkg::rsp_type  rsp_data
);
   import fpa_pkg::*;

   localparam int LAT = DATA_W + FRAC_BITS + 3;

   // The block never holds words off
   `FPA_CHECK(a_never_busy, !busy, "busy raised")

   // Each result follows a word taken a fixed latency earlier
   `FPA_CHECK_IMP(a_rsp_has_req, rsp_strobe, $past(start, LAT),
      "result without a word taken at the pipeline latency")

   // Divide by zero only for a divide, and then a zero result and no flag
   `FPA_CHECK_IMP(a_dbz_only_div, rsp_strobe && rsp_data.div_by_zero,
      $past(req_data.func, LAT) == FUNC_DIV && rsp_data.result == '0 && !rsp_data.flag,
      "divide-by-zero flag on a wrong result")

   // A comparison outcome comes with a zero result
   `FPA_CHECK_IMP(a_flag_zero_res, rsp_strobe && rsp_data.flag,
      rsp_data.result == '0, "compare flag with a non-zero result")

endmodule

bind fixed_point_alu_top fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (.*);
